### rtl/core/mdtks_pkg.sv
// shared types and constants for the tricube kernel smoother
// no dependencies
`timescale 1ns / 1ps

package mdtks_pkg;

  localparam int MaxOutputs = 64;
  localparam int MaxDims    = 4;
  localparam int IdxW       = $clog2(MaxOutputs);
  localparam int CntW       = $clog2(MaxOutputs + 1);
  localparam int WsumW      = 48;
  localparam int VsumW      = 64;

  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [15:0] OneQ15 = 16'h8000;
  localparam logic [WsumW-1:0] WsumMax = {WsumW{1'b1}};

  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpAccum  = 2'd1,
    OpFinish = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegNumDims = 3'd0,
    RegInvBw0  = 3'd1,
    RegInvBw1  = 3'd2,
    RegInvBw2  = 3'd3,
    RegInvBw3  = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StAccum,
    StFinRead,
    StFinDiv,
    StFinOut
  } state_e;

  // lane request: one coordinate pair, inverse bandwidth and a used flag
  typedef struct packed {
    logic [15:0] xi;
    logic [15:0] xo;
    logic [23:0] ibw;
    logic        used;
  } lane_req_t;

endpackage

### rtl/core/multi_dim_tricube_kernel_smoother_top.sv
// top level of the tricube kernel smoother: sequencer, sum memories, lanes
// depends on mdtks_pkg, mdtks_lane, mdtks_merge, mdtks_div
`timescale 1ns / 1ps

// An accumulate transfer streams over the loaded output points, one per cycle,
// through four kernel lanes (one per dimension) and a weight-merge pipeline.
// A finish transfer runs one 64-step divider per point, skipping the divider
// for a zero weight sum, and each result can be held by an output stall.
// Sums are cleared lazily by a per-point valid bit.
module multi_dim_tricube_kernel_smoother_top
  import mdtks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] coord_0_i,
  input  logic [15:0] coord_1_i,
  input  logic [15:0] coord_2_i,
  input  logic [15:0] coord_3_i,
  input  logic [15:0] sample_value_i,
  input  logic [15:0] sample_weight_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] smoothed_o,
  output logic        zero_weight_o,
  output logic [5:0]  point_index_o,
  output logic        last_o
);

  localparam int Lat = 11;

  logic [2:0]  num_dims_q;
  logic [23:0] inv_bw_q [MaxDims];
  logic [2:0]  dims;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= 3'd1;
      for (int i = 0; i < MaxDims; i++) inv_bw_q[i] <= 24'h010000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegNumDims: num_dims_q  <= cfg_data_i[2:0];
        RegInvBw0:  inv_bw_q[0] <= cfg_data_i;
        RegInvBw1:  inv_bw_q[1] <= cfg_data_i;
        RegInvBw2:  inv_bw_q[2] <= cfg_data_i;
        RegInvBw3:  inv_bw_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign dims = (num_dims_q == 3'd0) ? 3'd1 :
                (num_dims_q > 3'(MaxDims) ? 3'(MaxDims) : num_dims_q);

  // memories
  logic [63:0]      coord_mem [MaxOutputs];
  logic [WsumW-1:0] wsum_mem [MaxOutputs];
  logic [VsumW-1:0] vsum_mem [MaxOutputs];
  logic [MaxOutputs-1:0] sv_q, sv_d;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [63:0] xi_q;
  logic [15:0] val_q, sw_q;
  logic in_xfer, out_xfer;
  logic ovld_q;
  logic [15:0] osm_q;
  logic ozw_q, olast_q;
  logic [IdxW-1:0] oidx_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_xfer = ovld_q && !out_stall_i;

  // accumulate read stream
  logic [63:0] co_q;
  logic        rv_q;
  logic [IdxW-1:0] ridx_q;
  logic rdo, divdone, divstart;
  logic [15:0] quo;

  assign rdo = (state_q == StAccum) && (rd_q < cnt_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer && operation_i == OpLoad && cnt_q < CntW'(MaxOutputs))
      coord_mem[cnt_q[IdxW-1:0]] <= {coord_3_i, coord_2_i, coord_1_i, coord_0_i};
    co_q <= coord_mem[rd_q[IdxW-1:0]];
    if (in_xfer) begin
      xi_q  <= {coord_3_i, coord_2_i, coord_1_i, coord_0_i};
      val_q <= sample_value_i;
      sw_q  <= (sample_weight_i > OneQ15) ? OneQ15 : sample_weight_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      ridx_q <= '0;
    end else begin
      rv_q <= rdo;
      ridx_q <= rd_q[IdxW-1:0];
    end
  end

  lane_req_t req [MaxDims];
  logic [15:0] kv [MaxDims];
  for (genvar g = 0; g < MaxDims; g++) begin : g_lane
    assign req[g] = '{xi: xi_q[16*g +: 16], xo: co_q[16*g +: 16],
                      ibw: inv_bw_q[g], used: (3'(g) < dims)};
    mdtks_lane u_lane (.clk_i, .req_i(req[g]), .k_o(kv[g]));
  end

  logic [15:0] w;
  mdtks_merge u_merge (.clk_i, .k_i(kv), .sw_i(sw_q), .w_o(w));

  // delay line for valid and index through lanes plus merge
  logic [Lat-1:0]  dv_q;
  logic [IdxW-1:0] di_q [Lat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else dv_q <= {dv_q[Lat-2:0], rv_q};
  end
  always_ff @(posedge clk_i) begin
    di_q[0] <= ridx_q;
    for (int i = 1; i < Lat; i++) di_q[i] <= di_q[i-1];
  end

  // read-modify-write of the sums: read stage then update stage
  logic [WsumW-1:0] wr_q;
  logic [VsumW-1:0] vr_q;
  logic             ru_q;
  logic [15:0]      wu_q;
  logic [IdxW-1:0]  iu_q;
  logic [31:0]      pv_q;
  logic [WsumW-1:0] wnew;
  logic [VsumW-1:0] vnew, vsum, pext;
  logic [WsumW:0]   wadd;
  logic             uvld;
  logic [IdxW-1:0]  fidx;
  logic [IdxW-1:0]  fnext;

  assign uvld = dv_q[Lat-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ru_q <= 1'b0;
    else ru_q <= uvld;
  end
  assign fidx = rd_q[IdxW-1:0];
  // finish reads ahead so the sums of the current point are ready
  assign fnext = rd_d[IdxW-1:0];
  always_ff @(posedge clk_i) begin
    wr_q <= wsum_mem[uvld ? di_q[Lat-1] : fnext];
    vr_q <= vsum_mem[uvld ? di_q[Lat-1] : fnext];
    wu_q <= w;
    iu_q <= di_q[Lat-1];
    pv_q <= 32'($signed(val_q) * $signed({1'b0, w}));
  end

  logic rvalid;
  assign rvalid = sv_q[iu_q];
  assign wadd = {1'b0, (rvalid ? wr_q : '0)} + (WsumW+1)'(wu_q);
  assign wnew = wadd[WsumW] ? WsumMax : wadd[WsumW-1:0];
  assign pext = {{32{pv_q[31]}}, pv_q};
  assign vsum = (rvalid ? vr_q : '0) + pext;
  always_comb begin
    vnew = vsum;
    if (!pext[63] && !vr_q[63] && rvalid && vsum[63]) vnew = 64'h7fffffffffffffff;
    if (pext[63] && vr_q[63] && rvalid && !vsum[63]) vnew = 64'h8000000000000000;
  end
  always_ff @(posedge clk_i) begin
    if (ru_q) begin
      wsum_mem[iu_q] <= wnew;
      vsum_mem[iu_q] <= vnew;
    end
  end

  mdtks_div u_div (.clk_i, .rst_ni, .start_i(divstart), .num_i(vr_q),
                   .den_i(wr_q), .done_o(divdone), .quo_o(quo));

  logic fin_zero;
  assign fin_zero = !sv_q[fidx] || (wr_q == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          case (op_e'(operation_i))
            OpAccum:  if (cnt_q != '0) state_d = StAccum;
            OpFinish: if (cnt_q != '0) state_d = StFinRead;
            default: ;
          endcase
        end
      end
      StAccum:   if (!rdo && !rv_q && dv_q == '0 && !ru_q) state_d = StIdle;
      StFinRead: state_d = fin_zero ? StFinOut : StFinDiv;
      StFinDiv:  if (divdone) state_d = StFinOut;
      StFinOut: begin
        if (!ovld_q || out_xfer)
          state_d = (rd_q + 1'b1 == cnt_q) ? StIdle : StFinRead;
      end
      default: state_d = StIdle;
    endcase
  end

  assign divstart = (state_q == StFinRead) && !fin_zero;

  always_comb begin
    cnt_d = cnt_q; rd_d = rd_q; sv_d = sv_q;
    if (in_xfer) begin
      rd_d = '0;
      case (op_e'(operation_i))
        OpLoad:  if (cnt_q < CntW'(MaxOutputs)) cnt_d = cnt_q + 1'b1;
        OpClear: begin cnt_d = '0; sv_d = '0; end
        default: ;
      endcase
    end
    if (rdo) rd_d = rd_q + 1'b1;
    if (ru_q) sv_d[iu_q] = 1'b1;
    if (state_q == StFinOut && (!ovld_q || out_xfer)) begin
      sv_d[fidx] = 1'b0;
      rd_d = rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      rd_q    <= '0;
      sv_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      sv_q    <= sv_d;
      if (state_q == StFinOut && (!ovld_q || out_xfer)) ovld_q <= 1'b1;
      else if (out_xfer) ovld_q <= 1'b0;
    end
  end

  logic zflag_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StFinRead) zflag_q <= fin_zero;
    if (state_q == StFinOut && (!ovld_q || out_xfer)) begin
      osm_q   <= zflag_q ? 16'd0 : quo;
      ozw_q   <= zflag_q;
      oidx_q  <= fidx;
      olast_q <= (rd_q + 1'b1 == cnt_q);
    end
  end

  assign out_valid_o   = ovld_q;
  assign smoothed_o    = osm_q;
  assign zero_weight_o = ozw_q;
  assign point_index_o = oidx_q;
  assign last_o        = olast_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxOutputs)) else $error("point count overflow");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_upd_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ru_q |-> (state_q == StAccum)) else $error("sum update outside accumulate");

endmodule

### rtl/core/mdtks_lane.sv
// one tricube kernel lane, pipelined with at most one multiply per stage
// depends on mdtks_pkg
`timescale 1ns / 1ps

module mdtks_lane
  import mdtks_pkg::*;
(
  input  logic        clk_i,
  input  lane_req_t   req_i,
  output logic [15:0] k_o
);

  logic [16:0] d_q;
  logic [23:0] ibw_q;
  logic        used1_q;
  logic [40:0] u_q;
  logic        used2_q;
  logic [33:0] t2p_q;
  logic [16:0] u3_q;
  logic        z3_q, used3_q;
  logic [33:0] t3p_q;
  logic        z4_q, used4_q;
  logic [16:0] y5_q;
  logic        z5_q, used5_q;
  logic [33:0] y2p_q;
  logic [16:0] y6_q;
  logic        z6_q, used6_q;
  logic [33:0] y3p_q;
  logic        z7_q, used7_q;
  logic [16:0] diff;
  logic [16:0] y;

  assign diff = {req_i.xi[15], req_i.xi} - {req_i.xo[15], req_i.xo};
  assign y = OneQ16 - t3p_q[32:16];

  always_ff @(posedge clk_i) begin
    d_q     <= diff[16] ? 17'(-diff) : diff;
    ibw_q   <= req_i.ibw;
    used1_q <= req_i.used;
    u_q     <= 41'(d_q) * 41'(ibw_q);
    used2_q <= used1_q;
    t2p_q   <= u_q[16:0] * u_q[16:0];
    u3_q    <= u_q[16:0];
    z3_q    <= (u_q > 41'(OneQ16));
    used3_q <= used2_q;
    t3p_q   <= 34'(t2p_q[33:16]) * 34'(u3_q);
    z4_q    <= z3_q;
    used4_q <= used3_q;
    y5_q    <= y;
    z5_q    <= z4_q;
    used5_q <= used4_q;
    y2p_q   <= y5_q * y5_q;
    y6_q    <= y5_q;
    z6_q    <= z5_q;
    used6_q <= used5_q;
    y3p_q   <= 34'(y2p_q[33:16]) * 34'(y6_q);
    z7_q    <= z6_q;
    used7_q <= used6_q;
  end

  assign k_o = !used7_q ? OneQ15 : (z7_q ? 16'd0 : y3p_q[32:17]);

endmodule

### rtl/core/mdtks_div.sv
// radix-2 divider, signed 64-bit dividend by unsigned 48-bit divisor, saturated quotient
// depends on mdtks_pkg
`timescale 1ns / 1ps

module mdtks_div
  import mdtks_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VsumW-1:0] num_i,
  input  logic [WsumW-1:0] den_i,
  output logic             done_o,
  output logic [15:0]      quo_o
);

  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             neg_q, neg_d;
  logic [VsumW-1:0] n_q, n_d;
  logic [WsumW:0]   r_q, r_d;
  logic [WsumW-1:0] den_q, den_d;
  logic             done_q, done_d;
  logic [WsumW:0]   trial;
  logic [WsumW:0]   rsh;
  logic [VsumW-1:0] mag;
  logic             big;

  assign rsh   = {r_q[WsumW-1:0], n_q[VsumW-1]};
  assign trial = rsh - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q; n_d = n_q;
    r_d = r_q; den_d = den_q; done_d = 1'b0;
    if (start_i) begin
      neg_d  = num_i[VsumW-1];
      n_d    = num_i[VsumW-1] ? VsumW'(-num_i) : num_i;
      den_d  = den_i;
      r_d    = '0;
      cnt_d  = 7'(VsumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[WsumW]) begin
        r_d = trial;
        n_d = {n_q[VsumW-2:0], 1'b1};
      end else begin
        r_d = rsh;
        n_d = {n_q[VsumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    n_q   <= n_d;
    r_q   <= r_d;
    den_q <= den_d;
  end

  // magnitude may be 2^63 only for most negative dividend
  assign mag = n_q;
  always_comb begin
    big = (mag[VsumW-1:15] != '0);
    if (neg_q) begin
      if (big && !(mag == 64'h8000)) quo_o = 16'h8000;
      else quo_o = 16'(-mag[15:0]);
      if (mag[VsumW-1:16] != '0) quo_o = 16'h8000;
    end else begin
      quo_o = big ? 16'h7fff : mag[15:0];
    end
  end
  assign done_o = done_q;

endmodule

### rtl/core/mdtks_merge.sv
// merges lane kernels with the sample weight into one point weight
// depends on mdtks_pkg
`timescale 1ns / 1ps

module mdtks_merge
  import mdtks_pkg::*;
(
  input  logic        clk_i,
  input  logic [15:0] k_i [MaxDims],
  input  logic [15:0] sw_i,
  output logic [15:0] w_o
);

  logic [15:0] w1_q, w2_q, w3_q, k2_q, k3a_q, k3b_q;
  logic [15:0] sw1_q, sw2_q, sw3_q, w_r_q;
  logic [31:0] p1, p2, p3, pw;

  // dimensions folded in order, one floor per multiply
  assign p1 = k_i[0] * k_i[1];
  assign p2 = w1_q * k2_q;
  assign p3 = w2_q * k3b_q;
  assign pw = w3_q * sw3_q;

  always_ff @(posedge clk_i) begin
    w1_q  <= p1[30:15];
    k2_q  <= k_i[2];
    k3a_q <= k_i[3];
    sw1_q <= sw_i;
    w2_q  <= p2[30:15];
    k3b_q <= k3a_q;
    sw2_q <= sw1_q;
    w3_q  <= p3[30:15];
    sw3_q <= sw2_q;
    w_r_q <= pw[30:15];
  end
  assign w_o = w_r_q;

endmodule
